[sv/nlh_pkg.sv]
// Shared types, constants and helper functions of the normalized line hash unit.
`timescale 1ns / 1ps

package nlh_pkg;

  // Width of the normalized length counter and of the norm_length field.
  localparam int LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

  // FNV-1a 32-bit constants.
  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  // Character codes used by the normaliser.
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_FF      = 8'h0C;
  localparam logic [7:0] CHAR_VT      = 8'h0B;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IGNORE_CASE         = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IGNORE_ALL_SPACE    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IGNORE_SPACE_CHANGE = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STRIP_TRAILING_CR   = 2'd3;

  // Normalisation mode bits held by the top level.
  typedef struct packed {
    logic ignore_case;
    logic ignore_all_space;
    logic ignore_space_change;
    logic strip_trailing_cr;
  } cfg_t;

  // Decision for one byte, passed from the filter to the hash core.
  typedef struct packed {
    logic       emit;       // fold value into the hash
    logic       mark_space; // whitespace under space-change mode
    logic       eol;        // last item of the line
    logic [7:0] value;      // byte after case folding
  } byte_ctl_t;

  // True for space, tab, CR, FF and VT.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) ||
           (c == CHAR_FF) || (c == CHAR_VT);
  endfunction

  // Length increment that stops at the top of the counter range.
  function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] n);
    return (n == LENGTH_MAX) ? n : n + LENGTH_BITS'(1);
  endfunction

endpackage

[sv/nlh_item_if.sv]
// Input channel carrying one raw byte of a text line per transaction.
`timescale 1ns / 1ps

interface nlh_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_byte;
  logic       end_of_line;

  modport source (output valid, output char_byte, output has_byte, output end_of_line,
                  input ready);
  modport sink (input valid, input char_byte, input has_byte, input end_of_line,
                output ready);
endinterface

[sv/nlh_result_if.sv]
// Output channel carrying the hash and normalized length of one line per transaction.
`timescale 1ns / 1ps

interface nlh_result_if;
  logic                         valid;
  logic                         ready;
  logic [31:0]                  line_hash;
  logic [nlh_pkg::LENGTH_BITS-1:0] norm_length;

  modport source (output valid, output line_hash, output norm_length, input ready);
  modport sink (input valid, input line_hash, input norm_length, output ready);
endinterface

[sv/nlh_cfg_if.sv]
// Configuration write channel: register index and write data per transaction.
`timescale 1ns / 1ps

interface nlh_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [nlh_pkg::CFG_INDEX_BITS-1:0]  index;
  logic                                data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/nlh_byte_filter.sv]
// Byte classifier: decides whether a byte is dropped, marks a space or is hashed.
`timescale 1ns / 1ps

module nlh_byte_filter (
  input  nlh_pkg::cfg_t      cfg,
  input  logic [7:0]         char_byte,
  input  logic               has_byte,
  input  logic               end_of_line,
  output nlh_pkg::byte_ctl_t ctl
);

  logic ws;
  logic drop_cr;
  logic upper;

  // Classify the byte against the current modes.
  always_comb begin
    ws      = nlh_pkg::is_ws(char_byte);
    drop_cr = cfg.strip_trailing_cr && end_of_line && (char_byte == nlh_pkg::CHAR_CR);
    upper   = (char_byte >= nlh_pkg::CHAR_UPPER_A) && (char_byte <= nlh_pkg::CHAR_UPPER_Z);

    ctl.eol        = end_of_line;
    ctl.emit       = 1'b0;
    ctl.mark_space = 1'b0;
    ctl.value      = (cfg.ignore_case && upper) ? (char_byte | nlh_pkg::CASE_BIT) : char_byte;

    // All-space mode takes precedence over space-change mode.
    if (has_byte && !drop_cr) begin
      if (ws && cfg.ignore_all_space) begin
        ctl.emit = 1'b0;
      end else if (ws && cfg.ignore_space_change) begin
        ctl.mark_space = 1'b1;
      end else begin
        ctl.emit = 1'b1;
      end
    end
  end

endmodule

[sv/nlh_hash_core.sv]
// FNV-1a accumulator with a speculative hash for a deferred collapsed space.
`timescale 1ns / 1ps

module nlh_hash_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  nlh_pkg::byte_ctl_t              ctl,
  output logic [31:0]                     line_hash,
  output logic [nlh_pkg::LENGTH_BITS-1:0] line_length
);

  // Running line state.
  logic [31:0]                     hash_accum;
  logic [nlh_pkg::LENGTH_BITS-1:0] length_count;
  logic                            pending_space;
  // Hash and length as they would be once the pending space is written.
  logic [31:0]                     spec_hash;
  logic [nlh_pkg::LENGTH_BITS-1:0] spec_length;

  logic [31:0]                     base_hash;
  logic [nlh_pkg::LENGTH_BITS-1:0] base_length;
  logic [31:0]                     mul_operand;
  logic [31:0]                     product;
  logic [nlh_pkg::LENGTH_BITS-1:0] inc_length;
  logic [31:0]                     hash_accum_next;
  logic [nlh_pkg::LENGTH_BITS-1:0] length_count_next;

  // One shared constant multiplier: a byte either marks a space or is hashed.
  always_comb begin
    base_hash   = pending_space ? spec_hash : hash_accum;
    base_length = pending_space ? spec_length : length_count;
    mul_operand = ctl.mark_space ? (hash_accum ^ {24'd0, nlh_pkg::CHAR_SPACE})
                                 : (base_hash ^ {24'd0, ctl.value});
    product     = 32'(mul_operand * nlh_pkg::FNV_PRIME);
    inc_length  = nlh_pkg::sat_inc(ctl.mark_space ? length_count : base_length);

    hash_accum_next   = ctl.emit ? product : hash_accum;
    length_count_next = ctl.emit ? inc_length : length_count;
  end

  assign line_hash   = hash_accum_next;
  assign line_length = length_count_next;

  // Control state: a line end starts the next line from the offset basis.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_accum    <= nlh_pkg::FNV_BASIS;
      length_count  <= '0;
      pending_space <= 1'b0;
    end else if (step) begin
      if (ctl.eol) begin
        hash_accum    <= nlh_pkg::FNV_BASIS;
        length_count  <= '0;
        pending_space <= 1'b0;
      end else begin
        hash_accum   <= hash_accum_next;
        length_count <= length_count_next;
        if (ctl.mark_space) begin
          pending_space <= 1'b1;
        end else if (ctl.emit) begin
          pending_space <= 1'b0;
        end
      end
    end
  end

  // Speculative values are only read while a space is pending.
  always_ff @(posedge clk) begin
    if (step && ctl.mark_space) begin
      spec_hash   <= product;
      spec_length <= inc_length;
    end
  end

endmodule

[sv/normalized_line_hash_unit.sv]
// Top level of the normalized line hash unit: channel registers and mode registers.
//
// Usage: bytes of a text line arrive on the items channel, one per transaction,
// with has_byte = 0 for an item that carries no byte, such as one that only
// closes a line, and end_of_line = 1 on the last item of each line. For every
// item with end_of_line = 1 one transaction appears on the results channel with
// the FNV-1a hash of the normalized line and its length (saturating at all ones).
// Modes are written through the cfg channel (index 0 ignore_case, 1
// ignore_all_space, 2 ignore_space_change, 3 strip_trailing_cr) while no line
// is in flight; cfg.ready is always high.
// An accepted item is processed from the input register; a line's result is
// loaded into the result register and is held there until it is taken.
// Throughput: one item per cycle while no line end waits on a stalled result, set
// by the single constant multiply in the hash loop; a whitespace byte pre-computes
// the hash of a collapsed space so a following byte still needs only one multiply.
// Reset (rst, synchronous) clears both channel registers, all modes and the
// line state. When the receiver stalls, the finished result is held; items that
// do not end a line keep flowing, and an item ending the next line waits in the
// input register, which then drops items.ready.
`timescale 1ns / 1ps

module normalized_line_hash_unit (
  input logic          clk,
  input logic          rst,
  nlh_item_if.sink     items,
  nlh_result_if.source results,
  nlh_cfg_if.sink      cfg
);

  nlh_pkg::cfg_t                   mode;
  nlh_pkg::byte_ctl_t              ctl;

  // Input register.
  logic                            s1_valid;
  logic [7:0]                      s1_byte;
  logic                            s1_has;
  logic                            s1_eol;

  // Result register.
  logic                            res_valid;
  logic [31:0]                     res_hash;
  logic [nlh_pkg::LENGTH_BITS-1:0] res_length;

  logic                            step;
  logic                            load_result;
  logic [31:0]                     line_hash;
  logic [nlh_pkg::LENGTH_BITS-1:0] line_length;

  // Mode registers, written one bit per transaction.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        nlh_pkg::REG_IGNORE_CASE:         mode.ignore_case         <= cfg.data;
        nlh_pkg::REG_IGNORE_ALL_SPACE:    mode.ignore_all_space    <= cfg.data;
        nlh_pkg::REG_IGNORE_SPACE_CHANGE: mode.ignore_space_change <= cfg.data;
        nlh_pkg::REG_STRIP_TRAILING_CR:   mode.strip_trailing_cr   <= cfg.data;
        default:                          mode                     <= mode;
      endcase
    end
  end

  // An item is processed unless it ends a line while the result slot is full and not being taken.
  assign step        = s1_valid && (!s1_eol || !res_valid || results.ready);
  assign load_result = step && s1_eol;
  assign items.ready = !s1_valid || step;

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_byte <= items.char_byte;
      s1_has  <= items.has_byte;
      s1_eol  <= items.end_of_line;
    end
  end

  nlh_byte_filter u_filter (
    .cfg         (mode),
    .char_byte   (s1_byte),
    .has_byte    (s1_has),
    .end_of_line (s1_eol),
    .ctl         (ctl)
  );

  nlh_hash_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .ctl         (ctl),
    .line_hash   (line_hash),
    .line_length (line_length)
  );

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_result) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (load_result) begin
      res_hash   <= line_hash;
      res_length <= line_length;
    end
  end

  assign results.valid       = res_valid;
  assign results.line_hash   = res_hash;
  assign results.norm_length = res_length;

endmodule

[sv/nlh_checker.sv]
// Port-level checker for the normalized line hash unit, bound to the top level.
`timescale 1ns / 1ps

module nlh_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_eol,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [31:0]                     res_hash,
  input logic [nlh_pkg::LENGTH_BITS-1:0] res_length
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_hash) && $stable(res_length))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A new result follows an accepted line-ending item, by way of the input and result registers.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(in_valid && in_ready && in_eol, 2))
    else $error("result without a line-ending item");

  // With the result slot empty the input is never blocked.
  assert property (@(posedge clk) disable iff (rst) !res_valid |-> in_ready)
    else $error("input stalled with empty result slot");

endmodule

bind normalized_line_hash_unit nlh_checker u_nlh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (items.valid),
  .in_ready   (items.ready),
  .in_eol     (items.end_of_line),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_hash   (results.line_hash),
  .res_length (results.norm_length)
);

[bench/normalized_line_hash_unit_tb.sv]
// Self-checking testbench of the normalized line hash unit against a line hash predictor.
`timescale 1ns / 1ps

module normalized_line_hash_unit_tb;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 115;

  // Hash and length expected for one finished line.
  typedef struct packed {
    logic [31:0]                     hash;
    logic [nlh_pkg::LENGTH_BITS-1:0] length;
  } line_result_t;

  // Scoreboard: tracks the normalising hash of the line in flight and keeps
  // the results of finished lines until the block hands them out.
  class line_hash_tracker;
    nlh_pkg::cfg_t                   mode;
    logic [31:0]                     running_hash;
    logic                            space_owed;
    logic [nlh_pkg::LENGTH_BITS-1:0] byte_count;
    line_result_t                    expected_q[$];
    int                              mismatches;

    function new();
      mode       = '0;
      mismatches = 0;
      start_line();
    endfunction

    function void start_line();
      running_hash = nlh_pkg::FNV_BASIS;
      space_owed   = 1'b0;
      byte_count   = '0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c inside {nlh_pkg::CHAR_SPACE, nlh_pkg::CHAR_TAB, nlh_pkg::CHAR_CR,
                       nlh_pkg::CHAR_FF, nlh_pkg::CHAR_VT};
    endfunction

    // One FNV-1a round; the length stops at the top of its range.
    function void fold(logic [7:0] v);
      running_hash = (running_hash ^ {24'd0, v}) * nlh_pkg::FNV_PRIME;
      if (byte_count != nlh_pkg::LENGTH_MAX) byte_count = byte_count + 1'b1;
    endfunction

    function void set_mode(logic [nlh_pkg::CFG_INDEX_BITS-1:0] idx, logic val);
      case (idx)
        nlh_pkg::REG_IGNORE_CASE:         mode.ignore_case         = val;
        nlh_pkg::REG_IGNORE_ALL_SPACE:    mode.ignore_all_space    = val;
        nlh_pkg::REG_IGNORE_SPACE_CHANGE: mode.ignore_space_change = val;
        nlh_pkg::REG_STRIP_TRAILING_CR:   mode.strip_trailing_cr   = val;
        default: ;
      endcase
    endfunction

    // Notes one accepted input transaction.
    function void absorb_item(logic [7:0] c, logic has_byte, logic eol);
      logic         drop;
      logic [7:0]   v;
      line_result_t done;
      if (has_byte) begin
        // Only the byte that closes the line counts as a trailing CR.
        drop = mode.strip_trailing_cr && eol && (c == nlh_pkg::CHAR_CR);
        // Dropping all whitespace takes precedence over collapsing it.
        if (!drop && mode.ignore_all_space && is_blank(c)) drop = 1'b1;
        if (!drop && mode.ignore_space_change && is_blank(c)) begin
          space_owed = 1'b1;
          drop       = 1'b1;
        end
        if (!drop) begin
          if (space_owed) begin
            fold(nlh_pkg::CHAR_SPACE);
            space_owed = 1'b0;
          end
          v = c;
          if (mode.ignore_case && c >= nlh_pkg::CHAR_UPPER_A && c <= nlh_pkg::CHAR_UPPER_Z)
            v = c | nlh_pkg::CASE_BIT;
          fold(v);
        end
      end
      if (eol) begin
        done.hash   = running_hash;
        done.length = byte_count;
        expected_q.push_back(done);
        start_line();
      end
    endfunction

    // Compares one result transaction with the oldest finished line.
    function void check_result(logic [31:0] got_hash,
                               logic [nlh_pkg::LENGTH_BITS-1:0] got_length);
      line_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no line pending, hash %08h length %0d",
                 $time, got_hash, got_length);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got_hash !== want.hash) begin
        $display("%0t: line_hash mismatch, expected %08h, actual %08h",
                 $time, want.hash, got_hash);
        mismatches++;
      end
      if (got_length !== want.length) begin
        $display("%0t: norm_length mismatch, expected %0d, actual %0d",
                 $time, want.length, got_length);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  nlh_item_if   items_ch ();
  nlh_result_if res_ch ();
  nlh_cfg_if    cfg_ch ();

  normalized_line_hash_unit dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  line_hash_tracker lines = new();
  int items_sent = 0;
  bit sender_steady = 1'b0;

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random byte biased towards whitespace and letters.
  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      case ($urandom_range(0, 4))
        0: return nlh_pkg::CHAR_SPACE;
        1: return nlh_pkg::CHAR_TAB;
        2: return nlh_pkg::CHAR_CR;
        3: return nlh_pkg::CHAR_FF;
        default: return nlh_pkg::CHAR_VT;
      endcase
    end
    if (r < 55) return 8'($urandom_range(nlh_pkg::CHAR_UPPER_A, nlh_pkg::CHAR_UPPER_Z));
    if (r < 70)
      return 8'($urandom_range(nlh_pkg::CHAR_UPPER_A, nlh_pkg::CHAR_UPPER_Z)) |
             nlh_pkg::CASE_BIT;
    return 8'($urandom_range(0, 255));
  endfunction

  // Sends one item transaction, with an optional idle gap before it.
  task automatic push_item(input logic [7:0] c, input logic has_byte, input logic eol);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid       <= 1'b1;
    items_ch.char_byte   <= c;
    items_ch.has_byte    <= has_byte;
    items_ch.end_of_line <= eol;
    @(posedge clk);
    while (items_ch.ready !== 1'b1) @(posedge clk);
    lines.absorb_item(c, has_byte, eol);
    if (has_byte || eol) items_sent++;
  endtask

  // Sends a line given as text, closed on its last byte or by an end marker.
  task automatic send_text(input string s, input bit close_by_marker);
    int k;
    for (k = 0; k < s.len(); k++)
      push_item(s[k], 1'b1, !close_by_marker && (k == s.len() - 1));
    if (close_by_marker) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Random line: mostly short, sometimes longer, with assorted endings and
  // the odd empty transaction in between.
  task automatic send_random_line();
    int n;
    int k;
    int ending;
    logic [7:0] c;
    sender_steady = ($urandom_range(0, 3) == 0);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    ending = (n == 0) ? 0 : $urandom_range(0, 99);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      c = random_char();
      if (k == n - 1 && ending >= 15) begin
        if (ending < 45) c = nlh_pkg::CHAR_CR;
        push_item(c, 1'b1, 1'b1);
      end else begin
        push_item(c, 1'b1, 1'b0);
      end
    end
    if (ending < 15) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Stops sending and waits until every finished line has come out.
  task automatic await_drain();
    items_ch.valid <= 1'b0;
    while (lines.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four mode registers in one burst of transactions.
  task automatic apply_modes(input nlh_pkg::cfg_t m);
    logic [nlh_pkg::CFG_INDEX_BITS-1:0] idx [4];
    logic                               wr_bit [4];
    int                                 k;
    idx[0] = nlh_pkg::REG_IGNORE_CASE;         wr_bit[0] = m.ignore_case;
    idx[1] = nlh_pkg::REG_IGNORE_ALL_SPACE;    wr_bit[1] = m.ignore_all_space;
    idx[2] = nlh_pkg::REG_IGNORE_SPACE_CHANGE; wr_bit[2] = m.ignore_space_change;
    idx[3] = nlh_pkg::REG_STRIP_TRAILING_CR;   wr_bit[3] = m.strip_trailing_cr;
    for (k = 0; k < 4; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= wr_bit[k];
      @(posedge clk);
      while (cfg_ch.ready !== 1'b1) @(posedge clk);
      lines.set_mode(idx[k], wr_bit[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Result sink: checks every result transaction and stalls at random,
  // with quiet stretches of constant readiness.
  initial begin : result_sink
    int rx_hold;
    int rx_quiet;
    rx_hold  = 0;
    rx_quiet = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        lines.check_result(res_ch.line_hash, res_ch.norm_length);
      if (rx_quiet > 0) begin
        rx_quiet--;
        res_ch.ready <= 1'b1;
      end else if (rx_hold > 0) begin
        rx_hold--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 4) rx_quiet = $urandom_range(20, 100);
        else rx_hold = pick_gap();
      end
    end
  end

  // Watchdog: ends the run when no transaction has happened for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((items_ch.valid === 1'b1 && items_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("normalized_line_hash_unit verification failed");
    $finish;
  end

  // Stimulus: directed lines, then random phases.
  initial begin : stimulus
    nlh_pkg::cfg_t m;
    int            ph;
    int            phase_start;
    int            line_no;
    items_ch.valid       = 1'b0;
    items_ch.char_byte   = '0;
    items_ch.has_byte    = 1'b0;
    items_ch.end_of_line = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = nlh_pkg::REG_IGNORE_CASE;
    cfg_ch.data          = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset modes: empty line, extreme bytes, a kept trailing CR and an end
    // marker whose byte must be ignored.
    send_text("", 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);
    send_text("A\015", 1'b0);
    send_text("x", 1'b1);
    await_drain();

    // Every mode on: dropping all whitespace wins over collapsing it.
    apply_modes(nlh_pkg::cfg_t'(4'hF));
    send_text(" Ab\011 c\014\013\015", 1'b0);
    await_drain();

    // Collapsing with CR stripping: leading run kept, trailing run dropped,
    // and a CR before an end marker is not stripped.
    m = '0;
    m.ignore_space_change = 1'b1;
    m.strip_trailing_cr   = 1'b1;
    apply_modes(m);
    send_text("\011Hi  Z \015", 1'b0);
    send_text("q \015", 1'b1);
    await_drain();

    // Case folding with all whitespace dropped.
    m = '0;
    m.ignore_case      = 1'b1;
    m.ignore_all_space = 1'b1;
    apply_modes(m);
    send_text("\013\014Q\015", 1'b0);
    await_drain();

    // Random phases, each under its own mode setting.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) m = '0;
      else if (ph == 1) m = nlh_pkg::cfg_t'(4'hF);
      else m = nlh_pkg::cfg_t'(4'($urandom_range(0, 15)));
      apply_modes(m);
      phase_start = items_sent;
      line_no = 0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_random_line();
        line_no++;
        // Now and then hold off until every pending result is out.
        if (line_no == 5 || $urandom_range(0, 49) == 0) await_drain();
      end
      await_drain();
    end

    items_ch.valid <= 1'b0;
    while (lines.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lines.mismatches == 0 && lines.expected_q.size() == 0) begin
      $display("normalized_line_hash_unit verification clean");
    end else begin
      $display("normalized_line_hash_unit verification failed");
    end
    $finish;
  end

endmodule
